// File: design/bsfd_pkg.sv
`timescale 1ns / 1ps

package bsfd_pkg;

   localparam int BUF_BYTES  = 8192;
   localparam int EMPTY_LEN  = 7;
   localparam int LEN_OFFSET = 2;

   localparam int CNT_W = $clog2(BUF_BYTES + 1);
   localparam int LEN_W = 14;
   localparam int PLEN_W = 32;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] START_CODE = 8'h3e;
   localparam logic [7:0] ESC_CODE   = 8'h3d;
   localparam logic [7:0] END_CODE   = 8'h3c;
   localparam logic [7:0] ESC_MASK   = 8'h10;

   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_ABORTED  = 2'd2;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

   localparam logic [1:0] PUSH_NONE = 2'd0;
   localparam logic [1:0] PUSH_ONE  = 2'd1;
   localparam logic [1:0] PUSH_TWO  = 2'd2;

   typedef struct packed {
      logic [7:0]       out_byte;
      logic             byte_valid;
      logic             frame_done;
      logic [1:0]       frame_status;
      logic [LEN_W-1:0] frame_length;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] push_cnt;
      logic       pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic [FIFO_CW-1:0] count;
      logic               room_two;
      logic               not_empty;
   } fifo_stat_type;

endpackage

// File: design/bsfd_rsp_fifo.sv
`timescale 1ns / 1ps

module bsfd_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  bsfd_pkg::fifo_ctl_type  ctl,
   input  bsfd_pkg::rsp_type       push0,
   input  bsfd_pkg::rsp_type       push1,
   output bsfd_pkg::rsp_type       head,
   output bsfd_pkg::fifo_stat_type stat
);
   import bsfd_pkg::*;

   rsp_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0] count_ff, count_in;
   logic [FIFO_AW-1:0] wr_next;

   assign wr_next = wr_ptr_ff + FIFO_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(ctl.push_cnt);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(ctl.pop);
      count_in  = count_ff + FIFO_CW'(ctl.push_cnt) - FIFO_CW'(ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push_cnt != PUSH_NONE) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (ctl.push_cnt == PUSH_TWO) begin
         mem_ff[wr_next] <= push1;
      end
   end

   assign head           = mem_ff[rd_ptr_ff];
   assign stat.count     = count_ff;
   assign stat.not_empty = (count_ff != '0);
   assign stat.room_two  = (count_ff <= FIFO_CW'(FIFO_DEPTH - 2));

endmodule

// File: design/byte_stuffed_frame_decoder_top.sv
`timescale 1ns / 1ps

// Byte-stuffed frame decoder. Raw link bytes enter on the req_ channel, one byte per beat.
// Decoded results leave on the rsp_ channel: a frame byte (rsp_byte_valid) or a frame
// status (rsp_frame_done with status and kept length); rsp_last marks the final result
// caused by one input byte, and a byte causes at most two results.
// A byte is captured in an input register and, once the queue has room for two results,
// decoded into a four-entry result queue; the head of that queue is presented on the rsp_
// ports and is taken at a rising edge while rsp_stall is low.
// Throughput is one byte per cycle while each byte yields at most one result and the
// receiver does not stall; the queue drains one result per cycle while rsp_stall is low,
// so bytes with two results fill it faster than it drains. While the input register
// holds a byte and the queue has fewer than two free entries, the byte is held and
// req_stall rises, so a stalled receiver backs up into req_stall without losing results.
// Reset closes any open frame, clears the escape flag and counters, and drops all
// queued results.
module byte_stuffed_frame_decoder_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_byte_valid,
   output logic                       rsp_frame_done,
   output logic [1:0]                 rsp_frame_status,
   output logic [bsfd_pkg::LEN_W-1:0] rsp_frame_length,
   output logic                       rsp_last
);
   import bsfd_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [7:0]        s1_byte_ff, s1_byte_in;
   logic              in_frame_ff, in_frame_in;
   logic              esc_ff, esc_in;
   logic [CNT_W-1:0]  raw_ff, raw_in;
   logic [CNT_W-1:0]  kept_ff, kept_in;
   logic [PLEN_W-1:0] plen_ff, plen_in;

   logic              s1_go;
   logic              req_take;
   logic              do_keep;
   logic [7:0]        keep_val;
   logic              len_known;
   logic              full;
   logic              emit;
   logic [CNT_W-1:0]  kept_keep;
   logic [PLEN_W-1:0] plen_keep;
   logic [CNT_W-1:0]  raw_inc;
   logic              short;

   rsp_type       res0, res1, head;
   fifo_ctl_type  fctl;
   fifo_stat_type fstat;

   assign s1_go     = s1_valid_ff && fstat.room_two;
   assign req_stall = s1_valid_ff && !fstat.room_two;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_byte_in  = req_rx_byte;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      raw_inc = raw_ff + CNT_W'(1);
      if (s1_byte_ff == END_CODE) begin
         do_keep  = esc_ff;
         keep_val = ESC_CODE;
      end else begin
         do_keep  = esc_ff || (s1_byte_ff != ESC_CODE);
         keep_val = esc_ff ? (s1_byte_ff | ESC_MASK) : s1_byte_ff;
      end
      len_known = kept_ff >= CNT_W'(LEN_OFFSET + 4);
      full      = len_known &&
                  ({{(PLEN_W + 1 - CNT_W){1'b0}}, kept_ff} >=
                   (33'(EMPTY_LEN) + {1'b0, plen_ff}));
      emit      = do_keep && !full;
      plen_keep = plen_ff;
      kept_keep = kept_ff;
      if (emit) begin
         kept_keep = kept_ff + CNT_W'(1);
         if (kept_ff >= CNT_W'(LEN_OFFSET) && kept_ff < CNT_W'(LEN_OFFSET + 4)) begin
            plen_keep = {plen_ff[PLEN_W-9:0], keep_val};
         end
      end
      short = (kept_keep < CNT_W'(EMPTY_LEN)) ||
              (kept_keep < CNT_W'(LEN_OFFSET + 4)) ||
              ({{(PLEN_W + 1 - CNT_W){1'b0}}, kept_keep} <
               (33'(EMPTY_LEN) + {1'b0, plen_keep}));
   end

   always_comb begin
      in_frame_in   = in_frame_ff;
      esc_in        = esc_ff;
      raw_in        = raw_ff;
      kept_in       = kept_ff;
      plen_in       = plen_ff;
      res0          = '0;
      res1          = '0;
      fctl.push_cnt = PUSH_NONE;
      fctl.pop      = fstat.not_empty && !rsp_stall;
      if (s1_go) begin
         if (s1_byte_ff == START_CODE) begin
            if (in_frame_ff) begin
               res0.frame_done   = 1'b1;
               res0.frame_status = STATUS_ABORTED;
               res0.frame_length = LEN_W'(kept_ff);
               res0.last         = 1'b1;
               fctl.push_cnt     = PUSH_ONE;
            end
            in_frame_in = 1'b1;
            esc_in      = 1'b0;
            raw_in      = '0;
            kept_in     = '0;
            plen_in     = '0;
         end else if (in_frame_ff) begin
            if (s1_byte_ff == END_CODE) begin
               in_frame_in = 1'b0;
               esc_in      = 1'b0;
               raw_in      = '0;
               kept_in     = '0;
               plen_in     = '0;
               if (emit) begin
                  res0.out_byte     = keep_val;
                  res0.byte_valid   = 1'b1;
                  res1.frame_done   = 1'b1;
                  res1.frame_status = short ? STATUS_SHORT : STATUS_GOOD;
                  res1.frame_length = LEN_W'(kept_keep);
                  res1.last         = 1'b1;
                  fctl.push_cnt     = PUSH_TWO;
               end else begin
                  res0.frame_done   = 1'b1;
                  res0.frame_status = short ? STATUS_SHORT : STATUS_GOOD;
                  res0.frame_length = LEN_W'(kept_keep);
                  res0.last         = 1'b1;
                  fctl.push_cnt     = PUSH_ONE;
               end
            end else begin
               raw_in  = raw_inc;
               esc_in  = !esc_ff && (s1_byte_ff == ESC_CODE);
               kept_in = kept_keep;
               plen_in = plen_keep;
               if (raw_inc >= CNT_W'(BUF_BYTES)) begin
                  in_frame_in = 1'b0;
                  esc_in      = 1'b0;
                  raw_in      = '0;
                  kept_in     = '0;
                  plen_in     = '0;
                  if (emit) begin
                     res0.out_byte     = keep_val;
                     res0.byte_valid   = 1'b1;
                     res1.frame_done   = 1'b1;
                     res1.frame_status = STATUS_OVERFLOW;
                     res1.frame_length = LEN_W'(kept_keep);
                     res1.last         = 1'b1;
                     fctl.push_cnt     = PUSH_TWO;
                  end else begin
                     res0.frame_done   = 1'b1;
                     res0.frame_status = STATUS_OVERFLOW;
                     res0.frame_length = LEN_W'(kept_keep);
                     res0.last         = 1'b1;
                     fctl.push_cnt     = PUSH_ONE;
                  end
               end else if (emit) begin
                  res0.out_byte   = keep_val;
                  res0.byte_valid = 1'b1;
                  res0.last       = 1'b1;
                  fctl.push_cnt   = PUSH_ONE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         in_frame_ff <= 1'b0;
         esc_ff      <= 1'b0;
         raw_ff      <= '0;
         kept_ff     <= '0;
         plen_ff     <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         in_frame_ff <= in_frame_in;
         esc_ff      <= esc_in;
         raw_ff      <= raw_in;
         kept_ff     <= kept_in;
         plen_ff     <= plen_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
   end

   bsfd_rsp_fifo u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .ctl   (fctl),
      .push0 (res0),
      .push1 (res1),
      .head  (head),
      .stat  (fstat)
   );

   assign rsp_valid        = fstat.not_empty;
   assign rsp_out_byte     = head.out_byte;
   assign rsp_byte_valid   = head.byte_valid;
   assign rsp_frame_done   = head.frame_done;
   assign rsp_frame_status = head.frame_status;
   assign rsp_frame_length = head.frame_length;
   assign rsp_last         = head.last;

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fstat.count <= FIFO_CW'(FIFO_DEPTH))
      else $error("Result queue count exceeds its depth.");

   a_idle_counts: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (kept_ff == '0 && raw_ff == '0 && !esc_ff))
      else $error("Frame counters are not clear while no frame is open.");

   a_raw_bound: assert property (@(posedge clock) disable iff (reset)
      raw_ff < CNT_W'(BUF_BYTES) && kept_ff <= raw_ff)
      else $error("Frame byte counters are out of range.");

   a_done_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> !rsp_byte_valid && rsp_last)
      else $error("A status beat also carries a frame byte or is not last.");

endmodule

// File: dv/frame_decode_checker.sv
`timescale 1ns / 1ps

module frame_decode_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [7:0]                 rsp_out_byte,
   input  logic                       rsp_byte_valid,
   input  logic                       rsp_frame_done,
   input  logic [1:0]                 rsp_frame_status,
   input  logic [bsfd_pkg::LEN_W-1:0] rsp_frame_length,
   input  logic                       rsp_last,
   output int                         mismatch_count,
   output int                         results_pending
);
   import bsfd_pkg::*;

   rsp_type     expected_results[$];
   rsp_type     byte_results[2];
   int          byte_result_count;
   logic        frame_open;
   logic        esc_armed;
   int          raw_bytes;
   int          kept_bytes;
   logic [31:0] len_field;

   function automatic void add_result(logic [7:0] data, logic data_valid, logic done,
                                      logic [1:0] status);
      byte_results[byte_result_count] = '{out_byte: data, byte_valid: data_valid,
                                          frame_done: done, frame_status: status,
                                          frame_length: done ? LEN_W'(kept_bytes) : '0,
                                          last: 1'b0};
      byte_result_count++;
   endfunction

   function automatic void clear_frame();
      esc_armed = 1'b0;
      raw_bytes = 0;
      kept_bytes = 0;
      len_field = '0;
   endfunction

   function automatic longint frame_limit();
      return longint'(EMPTY_LEN) + longint'({32'd0, len_field});
   endfunction

   function automatic void keep_byte(logic [7:0] value);
      if (kept_bytes >= LEN_OFFSET + 4 && longint'(kept_bytes) >= frame_limit()) return;
      if (kept_bytes >= LEN_OFFSET && kept_bytes < LEN_OFFSET + 4) begin
         len_field = {len_field[23:0], value};
      end
      kept_bytes++;
      add_result(value, 1'b1, 1'b0, STATUS_GOOD);
   endfunction

   function automatic void decode_byte(logic [7:0] rx);
      logic [1:0] status;
      byte_result_count = 0;
      if (rx == START_CODE) begin
         if (frame_open) add_result(8'h00, 1'b0, 1'b1, STATUS_ABORTED);
         frame_open = 1'b1;
         clear_frame();
      end else if (frame_open) begin
         if (rx == END_CODE) begin
            if (esc_armed) keep_byte(ESC_CODE);
            if (kept_bytes < EMPTY_LEN || kept_bytes < LEN_OFFSET + 4 ||
                longint'(kept_bytes) < frame_limit()) begin
               status = STATUS_SHORT;
            end else begin
               status = STATUS_GOOD;
            end
            add_result(8'h00, 1'b0, 1'b1, status);
            frame_open = 1'b0;
            clear_frame();
         end else begin
            raw_bytes++;
            if (esc_armed) begin
               esc_armed = 1'b0;
               keep_byte(rx | ESC_MASK);
            end else if (rx == ESC_CODE) begin
               esc_armed = 1'b1;
            end else begin
               keep_byte(rx);
            end
            if (raw_bytes >= BUF_BYTES) begin
               add_result(8'h00, 1'b0, 1'b1, STATUS_OVERFLOW);
               frame_open = 1'b0;
               clear_frame();
            end
         end
      end
      if (byte_result_count > 0) byte_results[byte_result_count-1].last = 1'b1;
      for (int k = 0; k < byte_result_count; k++) expected_results.push_back(byte_results[k]);
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatch_count++;
         $display("%0t rsp_%s expected %0h actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_results.delete();
         frame_open = 1'b0;
         clear_frame();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               $display({"%0t result expected none actual byte %0h valid %0b done %0b",
                         " status %0d length %0d last %0b"},
                        $time, rsp_out_byte, rsp_byte_valid, rsp_frame_done,
                        rsp_frame_status, rsp_frame_length, rsp_last);
            end else begin
               want = expected_results.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("byte_valid", want.byte_valid, rsp_byte_valid);
               check_field("frame_done", want.frame_done, rsp_frame_done);
               check_field("frame_status", want.frame_status, rsp_frame_status);
               check_field("frame_length", want.frame_length, rsp_frame_length);
               check_field("last", want.last, rsp_last);
            end
         end
         if (req_valid && !req_stall) decode_byte(req_rx_byte);
      end
      results_pending <= expected_results.size();
   end

endmodule

// File: dv/byte_stuffed_frame_decoder_top_tb.sv
`timescale 1ns / 1ps

module byte_stuffed_frame_decoder_top_tb;
   import bsfd_pkg::*;

   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int RANDOM_ITEMS = 500;

   localparam logic [7:0] DIRECTED_BYTES [20] = '{
      8'h00, 8'hff, END_CODE,
      START_CODE, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, ESC_CODE, END_CODE,
      START_CODE, 8'h11, ESC_CODE, ESC_CODE, ESC_CODE, START_CODE, END_CODE, 8'h80
   };

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [7:0]       req_rx_byte = 8'h00;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [7:0]       rsp_out_byte;
   logic             rsp_byte_valid;
   logic             rsp_frame_done;
   logic [1:0]       rsp_frame_status;
   logic [LEN_W-1:0] rsp_frame_length;
   logic             rsp_last;

   int mismatch_count;
   int results_pending;
   int cycle_count = 0;
   int items_sent = 0;
   int burst_left = 0;
   int stall_left = 0;

   byte_stuffed_frame_decoder_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_frame_done(rsp_frame_done),
      .rsp_frame_status(rsp_frame_status),
      .rsp_frame_length(rsp_frame_length),
      .rsp_last(rsp_last)
   );

   frame_decode_checker decode_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_byte_valid(rsp_byte_valid),
      .rsp_frame_done(rsp_frame_done),
      .rsp_frame_status(rsp_frame_status),
      .rsp_frame_length(rsp_frame_length),
      .rsp_last(rsp_last),
      .mismatch_count(mismatch_count),
      .results_pending(results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("byte_stuffed_frame_decoder_top_tb NOT OK");
         $finish;
      end
   end

   // The receiver alternates stall stretches with free runs, now and then a long free run.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_left <= $urandom_range(0, ($urandom_range(0, 3) == 0) ? 60 : 6);
      end else begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 11);
      end
   end

   task automatic send_byte(logic [7:0] rx);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 200 : 24);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic send_data(logic [7:0] value);
      if (value == START_CODE || value == ESC_CODE || value == END_CODE) begin
         send_byte(ESC_CODE);
         send_byte(value & ~ESC_MASK);
      end else if (value[4] && $urandom_range(0, 5) == 0) begin
         send_byte(ESC_CODE);
         send_byte(($urandom_range(0, 1) == 0) ? value : (value & ~ESC_MASK));
      end else begin
         send_byte(value);
      end
   endtask

   task automatic send_frame();
      int unsigned plen;
      logic [31:0] len_value;
      int body_len;
      int ending;
      logic [7:0] noise;
      plen = $urandom_range(0, 10);
      len_value = ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'(plen);
      body_len = EMPTY_LEN + plen;
      case ($urandom_range(0, 5))
         0: begin
            body_len = $urandom_range(0, body_len);
         end
         1: begin
            body_len += $urandom_range(1, 4);
         end
         default: ;
      endcase
      send_byte(START_CODE);
      for (int k = 0; k < body_len; k++) begin
         if ($urandom_range(0, 59) == 0) send_byte(8'($urandom));
         if (k >= LEN_OFFSET && k < LEN_OFFSET + 4) begin
            send_data(len_value[8*(LEN_OFFSET+3-k) +: 8]);
         end else begin
            send_data(8'($urandom));
         end
      end
      // A frame left open here is aborted by the next start byte.
      ending = $urandom_range(0, 11);
      if (ending != 0) begin
         if (ending == 1) send_byte(ESC_CODE);
         send_byte(END_CODE);
      end
      repeat ($urandom_range(0, 2)) begin
         noise = 8'($urandom);
         if (noise == START_CODE) noise = ~noise;
         send_byte(noise);
      end
   endtask

   // Fills the frame buffer without an end byte. With keep_all the length field
   // is at its maximum and no escapes are sent, so every byte is kept.
   task automatic send_overflow_frame(logic keep_all);
      logic [7:0] rx;
      send_byte(START_CODE);
      for (int k = 0; k < BUF_BYTES; k++) begin
         if (keep_all && k < LEN_OFFSET) begin
            rx = 8'h00;
         end else if (keep_all && k < LEN_OFFSET + 4) begin
            rx = 8'hff;
         end else begin
            do rx = 8'($urandom);
            while (rx == START_CODE || rx == END_CODE || (keep_all && rx == ESC_CODE));
         end
         send_byte(rx);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (DIRECTED_BYTES[k]) send_byte(DIRECTED_BYTES[k]);
      while (items_sent < RANDOM_ITEMS / 2) send_frame();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (results_pending != 0);
      while (items_sent < RANDOM_ITEMS + 20) send_frame();
      send_overflow_frame(1'b1);
      send_overflow_frame(1'b0);
      send_byte(END_CODE);
      send_byte(ESC_CODE);
      repeat (4) send_frame();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("byte_stuffed_frame_decoder_top_tb OK");
      end else begin
         $display("byte_stuffed_frame_decoder_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: files.f
design/bsfd_pkg.sv
design/bsfd_rsp_fifo.sv
design/byte_stuffed_frame_decoder_top.sv
dv/frame_decode_checker.sv
dv/byte_stuffed_frame_decoder_top_tb.sv
